FILE: sv/dpr_pkg.sv
// ----------------------------------------------------------------------------
// dpr_pkg
// Shared types, character codes and helpers for the debug packet receiver.
// ----------------------------------------------------------------------------
package dpr_pkg;

    localparam int PAYLOAD_BUFFER_BYTES = 64;

    localparam logic [7:0] CH_START = 8'h24;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_ACK   = 8'h2B;
    localparam logic [7:0] CH_NAK   = 8'h2D;
    localparam logic [3:0] RETRY_RESET = 4'd10;

    typedef enum logic [3:0] {
        PH_HUNT = 4'b0001,
        PH_BODY = 4'b0010,
        PH_DIG1 = 4'b0100,
        PH_DIG2 = 4'b1000
    } phase_t;

    typedef enum logic [1:0] {
        EV_PAYLOAD  = 2'd0,
        EV_GOOD     = 2'd1,
        EV_BAD_SUM  = 2'd2,
        EV_TOO_LONG = 2'd3
    } event_t;

    typedef struct packed {
        event_t     event_res;
        logic [7:0] data;
        logic [5:0] length;
        logic [7:0] ack_char;
        logic       give_up;
        logic [7:0] received_sum;
        logic [7:0] computed_sum;
    } result_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            h.val = c[3:0];
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
        begin
            // lower nibble of 'a'..'f' and 'A'..'F' is 1..6
            h.val = c[3:0] + 4'd9;
        end
        else
        begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

FILE: sv/debug_packet_receiver.sv
// ----------------------------------------------------------------------------
// debug_packet_receiver
// Frames '$' payload '#' hh packets from a received byte stream.
// ----------------------------------------------------------------------------
// One received byte is taken per cycle and its result, if any, is registered
// in the queue: framing, sum and checksum compare are one pass of next-state
// logic on the byte. Results go through a two-entry output queue, so bytes
// keep flowing while fewer than two results wait; in_ready drops only when both
// entries are full. The '$', the '#' and the first checksum digit give no
// transaction on the output. retry_limit may be written only while idle.
module debug_packet_receiver #(
    parameter int PAYLOAD_BUFFER_BYTES = dpr_pkg::PAYLOAD_BUFFER_BYTES
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [3:0] cfg_wdata,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] event_res,
    output logic [7:0] data,
    output logic [5:0] length,
    output logic [7:0] ack_char,
    output logic       give_up,
    output logic [7:0] received_sum,
    output logic [7:0] computed_sum
);

    localparam int CW = $clog2(PAYLOAD_BUFFER_BYTES + 1);

    dpr_pkg::phase_t phase_reg, phase_next;
    logic [7:0]    sum_reg, sum_next;
    logic [CW-1:0] count_reg, count_next;
    logic [3:0]    high_reg, high_next;
    logic          derr_reg, derr_next;
    logic [3:0]    fail_reg, fail_next;
    logic [3:0]    limit_reg;

    dpr_pkg::result_t fifo_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] fill_reg;

    dpr_pkg::result_t res;
    logic       has_res;
    logic       accept, push, pop;
    dpr_pkg::hex_t hx;
    logic [CW-1:0] count_inc;
    logic [CW+6:0] count_ext;
    logic [5:0]    len_sat;
    logic [3:0]    lim, fail_inc;
    logic          fail_hit;
    logic [7:0]    rx_sum;

    assign accept = in_valid && in_ready;
    assign pop    = out_valid && out_ready;
    assign push   = accept && has_res;
    assign in_ready  = (fill_reg != 2'd2);
    assign out_valid = (fill_reg != 2'd0);

    always_comb
    begin
        hx        = dpr_pkg::hex_decode(rx_byte);
        count_inc = count_reg + CW'(1);
        // a payload byte reports the count including itself
        count_ext = {7'd0, (phase_reg == dpr_pkg::PH_BODY) ? count_inc : count_reg};
        len_sat   = (count_ext > (CW+7)'(63)) ? 6'd63 : count_ext[5:0];
        lim       = (limit_reg == 4'd0) ? 4'd1 : limit_reg;
        fail_inc  = fail_reg + 4'd1;
        fail_hit  = (fail_inc >= lim) || (fail_inc == 4'd0);
        rx_sum    = {high_reg, hx.val};

        phase_next = phase_reg;
        sum_next   = sum_reg;
        count_next = count_reg;
        high_next  = high_reg;
        derr_next  = derr_reg;
        fail_next  = fail_reg;
        has_res    = 1'b0;
        res        = '0;

        case (phase_reg)
            dpr_pkg::PH_HUNT:
            begin
                if (rx_byte == dpr_pkg::CH_START)
                begin
                    phase_next = dpr_pkg::PH_BODY;
                    sum_next   = 8'd0;
                    count_next = '0;
                    high_next  = 4'd0;
                    derr_next  = 1'b0;
                end
            end
            dpr_pkg::PH_BODY:
            begin
                if (rx_byte == dpr_pkg::CH_HASH)
                begin
                    phase_next = dpr_pkg::PH_DIG1;
                end
                else
                begin
                    has_res    = 1'b1;
                    sum_next   = sum_reg + rx_byte;
                    // count stays below the buffer size while in the body
                    count_next = count_inc;
                    res.length = len_sat;
                    if (count_next >= CW'(PAYLOAD_BUFFER_BYTES))
                    begin
                        phase_next       = dpr_pkg::PH_HUNT;
                        res.event_res    = dpr_pkg::EV_TOO_LONG;
                        res.ack_char     = dpr_pkg::CH_NAK;
                        res.give_up      = fail_hit;
                        res.computed_sum = sum_next;
                        fail_next        = fail_hit ? 4'd0 : fail_inc;
                    end
                    else
                    begin
                        res.event_res = dpr_pkg::EV_PAYLOAD;
                        res.data      = rx_byte;
                    end
                end
            end
            dpr_pkg::PH_DIG1:
            begin
                high_next  = hx.val;
                derr_next  = !hx.ok;
                phase_next = dpr_pkg::PH_DIG2;
            end
            dpr_pkg::PH_DIG2:
            begin
                has_res          = 1'b1;
                phase_next       = dpr_pkg::PH_HUNT;
                derr_next        = derr_reg || !hx.ok;
                res.length       = len_sat;
                res.received_sum = rx_sum;
                res.computed_sum = sum_reg;
                if (!derr_next && rx_sum == sum_reg)
                begin
                    res.event_res = dpr_pkg::EV_GOOD;
                    res.ack_char  = dpr_pkg::CH_ACK;
                    fail_next     = 4'd0;
                end
                else
                begin
                    res.event_res = dpr_pkg::EV_BAD_SUM;
                    res.ack_char  = dpr_pkg::CH_NAK;
                    res.give_up   = fail_hit;
                    fail_next     = fail_hit ? 4'd0 : fail_inc;
                end
            end
            default:
            begin
                phase_next = dpr_pkg::PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= dpr_pkg::PH_HUNT;
            sum_reg    <= 8'd0;
            count_reg  <= '0;
            high_reg   <= 4'd0;
            derr_reg   <= 1'b0;
            fail_reg   <= 4'd0;
            limit_reg  <= dpr_pkg::RETRY_RESET;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            if (accept)
            begin
                phase_reg <= phase_next;
                sum_reg   <= sum_next;
                count_reg <= count_next;
                high_reg  <= high_next;
                derr_reg  <= derr_next;
                fail_reg  <= fail_next;
            end
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            fill_reg <= fill_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    // result queue payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= res;
        end
    end

    assign event_res    = fifo_reg[rd_ptr_reg].event_res;
    assign data         = fifo_reg[rd_ptr_reg].data;
    assign length       = fifo_reg[rd_ptr_reg].length;
    assign ack_char     = fifo_reg[rd_ptr_reg].ack_char;
    assign give_up      = fifo_reg[rd_ptr_reg].give_up;
    assign received_sum = fifo_reg[rd_ptr_reg].received_sum;
    assign computed_sum = fifo_reg[rd_ptr_reg].computed_sum;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg != 2'd3)
        else $error("result queue overfilled");

    a_giveup_nak: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && give_up |-> ack_char == dpr_pkg::CH_NAK)
        else $error("give-up without nak");

    a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res == dpr_pkg::EV_PAYLOAD |->
            ack_char == 8'd0 && computed_sum == 8'd0 && !give_up)
        else $error("payload transaction carries verdict fields");

    a_digit_order: assert property (@(posedge clk) disable iff (!rst_n)
        accept && phase_reg == dpr_pkg::PH_DIG1 |=> phase_reg == dpr_pkg::PH_DIG2)
        else $error("second checksum digit skipped");

endmodule
